[rtl/sitbd_pkg.sv]
package sitbd_pkg;

  // Input item kinds.
  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } command_t;

  // Characters that the alphabet check and the sign and error outputs use.
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_NONE  = 8'd0;

  // Register file: one register on a 32-bit data bus, word index taken from paddr[2].
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_DIGIT_COUNT = 1'b0;
  localparam logic [7:0] DIGIT_COUNT_RST = 8'd10;

  // Source of the character loaded into the output register.
  typedef enum logic [1:0] {
    OSEL_SIGN  = 2'd0,
    OSEL_DIGIT = 2'd1,
    OSEL_BAD   = 2'd2
  } out_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     start;
    logic     load;
    logic     scan_en;
    logic     div_step;
    logic     push;
    logic     pop;
    logic     tbl_rd;
    logic     out_ld;
    out_sel_t out_sel;
    logic     out_last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_lt2;
    logic chk_bad;
    logic scan_done;
    logic div_last;
    logic quot_zero;
    logic stack_empty;
    logic neg;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/sitbd_ctrl.sv]
module sitbd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  sitbd_pkg::dp_sts_t   sts,
  output sitbd_pkg::ctrl_cmd_t cmd
);
  import sitbd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_PUSH = 9'b000001000,
    S_SIGN = 9'b000010000,
    S_POP  = 9'b000100000,
    S_TBL  = 9'b001000000,
    S_EMIT = 9'b010000000,
    S_BAD  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_CONVERT) begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        priority if (sts.n_lt2 || sts.chk_bad) begin
          state_nxt = S_BAD;
        end else if (sts.scan_done) begin
          state_nxt = S_DIV;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        // The dividend register now holds the quotient for the next digit.
        cmd.push  = 1'b1;
        state_nxt = sts.quot_zero ? S_SIGN : S_DIV;
      end
      S_SIGN: begin
        if (!sts.neg) begin
          state_nxt = S_POP;
        end else if (sts.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_sel = OSEL_SIGN;
          state_nxt   = S_POP;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_TBL;
      end
      S_TBL: begin
        cmd.tbl_rd = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld   = 1'b1;
          cmd.out_sel  = OSEL_DIGIT;
          cmd.out_last = sts.stack_empty;
          state_nxt    = sts.stack_empty ? S_IDLE : S_POP;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.out_ld  = 1'b1;
          cmd.out_sel = OSEL_BAD;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/sitbd_dp.sv]
module sitbd_dp #(
  parameter int MAX_DIGITS   = 128,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sitbd_pkg::ctrl_cmd_t           cmd,
  output sitbd_pkg::dp_sts_t             sts,
  input  logic [7:0]                     digit_count,
  input  logic [6:0]                     in_digit_index,
  input  logic [7:0]                     in_digit_char,
  input  logic signed [NUMBER_WIDTH-1:0] in_number,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     out_char_out,
  output logic                           out_last,
  output logic                           out_base_invalid
);
  import sitbd_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W = $clog2(NUMBER_WIDTH);
  localparam int SP_W  = $clog2(NUMBER_WIDTH + 1);

  // Alphabet table and digit stack.
  logic [7:0]       tbl_mem [MAX_DIGITS];
  logic [7:0]       tbl_q_r;
  logic [IDX_W-1:0] stk_mem [NUMBER_WIDTH];
  logic [IDX_W-1:0] stk_q_r;

  logic [CNT_W-1:0]        n_r;
  logic                    neg_r;
  logic [NUMBER_WIDTH-1:0] quot_r;
  logic [CNT_W-1:0]        rem_r;
  logic [CNT_W-1:0]        rem_nxt;
  logic [BIT_W-1:0]        bit_r;
  logic [SP_W-1:0]         sp_r;
  logic [SP_W-1:0]         sp_m1;
  logic [CNT_W-1:0]        scan_i_r;
  logic                    chk_v_r;
  logic [127:0]            seen_r;

  logic                    out_valid_r;
  logic [7:0]              out_char_r;
  logic                    out_last_r;
  logic                    out_inv_r;

  logic [8:0]              ld_idx_ext;
  logic                    ld_in_range;
  logic [8:0]              cnt_ext;
  logic [8:0]              neff_ext;
  logic [NUMBER_WIDTH-1:0] num_u;
  logic [NUMBER_WIDTH-1:0] mag;
  logic                    scan_issue;
  logic                    tbl_rd_en;
  logic [IDX_W-1:0]        tbl_rd_addr;
  logic                    bad_char;
  logic [CNT_W:0]          trial;
  logic [CNT_W:0]          diff;
  logic                    fits;

  assign ld_idx_ext  = 9'(in_digit_index);
  assign ld_in_range = ld_idx_ext < 9'(MAX_DIGITS);

  // A count above the table size is clipped to the table size.
  assign cnt_ext  = 9'(digit_count);
  assign neff_ext = (cnt_ext > 9'(MAX_DIGITS)) ? 9'(MAX_DIGITS) : cnt_ext;

  assign num_u = NUMBER_WIDTH'(in_number);
  assign mag   = num_u[NUMBER_WIDTH-1] ? (~num_u + 1'b1) : num_u;

  assign scan_issue  = cmd.scan_en && (scan_i_r != n_r);
  assign tbl_rd_en   = scan_issue || cmd.tbl_rd;
  assign tbl_rd_addr = cmd.tbl_rd ? stk_q_r : scan_i_r[IDX_W-1:0];
  assign sp_m1       = sp_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.load && ld_in_range) begin
      tbl_mem[ld_idx_ext[IDX_W-1:0]] <= in_digit_char;
    end
    if (tbl_rd_en) begin
      tbl_q_r <= tbl_mem[tbl_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[sp_r[BIT_W-1:0]] <= rem_r[IDX_W-1:0];
    end
    if (cmd.pop) begin
      stk_q_r <= stk_mem[sp_m1[BIT_W-1:0]];
    end
  end

  // Alphabet check: one entry per cycle, duplicates caught by a bitmap of
  // the characters seen so far. Only printable characters reach the bitmap.
  assign bad_char = (tbl_q_r == CH_MINUS) || (tbl_q_r == CH_PLUS) ||
                    (tbl_q_r <= CH_SPACE) || (tbl_q_r >= CH_DEL) ||
                    seen_r[tbl_q_r[6:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_i_r <= '0;
      chk_v_r  <= 1'b0;
    end else if (cmd.start) begin
      scan_i_r <= '0;
      chk_v_r  <= 1'b0;
    end else if (cmd.scan_en) begin
      if (scan_issue) begin
        scan_i_r <= scan_i_r + 1'b1;
      end
      chk_v_r <= scan_issue;
    end else begin
      chk_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      seen_r <= '0;
    end else if (cmd.scan_en && chk_v_r) begin
      seen_r[tbl_q_r[6:0]] <= 1'b1;
    end
  end

  // Restoring division, one quotient bit per cycle. The quotient shifts into
  // the dividend register, so it is ready as the next dividend.
  assign trial   = {rem_r, quot_r[NUMBER_WIDTH-1]};
  assign fits    = trial >= {1'b0, n_r};
  assign diff    = trial - {1'b0, n_r};
  assign rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r  <= '0;
      bit_r <= '0;
    end else if (cmd.start) begin
      n_r    <= neff_ext[CNT_W-1:0];
      neg_r  <= num_u[NUMBER_WIDTH-1];
      quot_r <= mag;
      rem_r  <= '0;
      bit_r  <= '0;
      sp_r   <= '0;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[NUMBER_WIDTH-2:0], fits};
      rem_r  <= rem_nxt;
      bit_r  <= bit_r + 1'b1;
    end else if (cmd.push) begin
      sp_r  <= sp_r + 1'b1;
      rem_r <= '0;
      bit_r <= '0;
    end else if (cmd.pop) begin
      sp_r <= sp_m1;
    end
  end

  // Output register: a new result may be loaded in the cycle the old one
  // is transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      unique case (cmd.out_sel)
        OSEL_SIGN: begin
          out_char_r <= CH_MINUS;
          out_last_r <= 1'b0;
          out_inv_r  <= 1'b0;
        end
        OSEL_DIGIT: begin
          out_char_r <= tbl_q_r;
          out_last_r <= cmd.out_last;
          out_inv_r  <= 1'b0;
        end
        default: begin
          out_char_r <= CH_NONE;
          out_last_r <= 1'b1;
          out_inv_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_out     = out_char_r;
  assign out_last         = out_last_r;
  assign out_base_invalid = out_inv_r;

  assign sts.n_lt2       = n_r < CNT_W'(2);
  assign sts.chk_bad     = chk_v_r && bad_char;
  assign sts.scan_done   = (scan_i_r == n_r) && !chk_v_r;
  assign sts.div_last    = bit_r == BIT_W'(NUMBER_WIDTH - 1);
  assign sts.quot_zero   = quot_r == '0;
  assign sts.stack_empty = sp_r == '0;
  assign sts.neg         = neg_r;
  assign sts.out_free    = !out_valid_r || out_ready;

endmodule

[rtl/signed_integer_to_base_digits_top.sv]
// Converts a signed NUMBER_WIDTH-bit number to text in a radix set by a
// loadable digit alphabet. A load item writes one alphabet byte; a convert
// item checks the first digit_count entries (at least two, all distinct,
// printable, no '+' or '-') and then sends '-' for a negative number and the
// digits most significant first, the final one marked last. A failed check
// gives one result with base_invalid and last set and char_out zero. Alphabet
// entries must be written before a conversion uses them; the table has no
// reset and no clearing pass. One item is processed at a time. A load leaves
// the block idle, ready for the next item. A conversion ends when its last
// character is loaded into the output register, and the next item is taken
// in the cycle after that. The check reads one table entry per cycle, and the
// digits come from one shared divider that produces one quotient bit per
// cycle. Output stalls hold the conversion while it waits to load a character.
// digit_count is written at byte address 0 of the register port.
module signed_integer_to_base_digits_top #(
  parameter int MAX_DIGITS   = 128,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [6:0]                          in_digit_index,
  input  logic [7:0]                          in_digit_char,
  input  logic signed [NUMBER_WIDTH-1:0]      in_number,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_char_out,
  output logic                                out_last,
  output logic                                out_base_invalid,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sitbd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [sitbd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [sitbd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import sitbd_pkg::*;

  logic [7:0] digit_count_r;
  logic       reg_sel;
  ctrl_cmd_t  cmd;
  dp_sts_t    sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1] == REG_DIGIT_COUNT;
  assign prdata  = reg_sel ? CFG_DATA_W'(digit_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= DIGIT_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      digit_count_r <= pwdata[7:0];
    end
  end

  sitbd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sitbd_dp #(
    .MAX_DIGITS   (MAX_DIGITS),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .digit_count      (digit_count_r),
    .in_digit_index   (in_digit_index),
    .in_digit_char    (in_digit_char),
    .in_number        (in_number),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_char_out     (out_char_out),
    .out_last         (out_last),
    .out_base_invalid (out_base_invalid)
  );

endmodule

[rtl/sitbd_checker.sv]
module sitbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_last,
  input logic       out_base_invalid
);
  import sitbd_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out) &&
    $stable(out_last) && $stable(out_base_invalid))
    else $error("result changed while stalled");

  // An invalid-alphabet result ends its run and carries a zero character.
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_base_invalid |-> out_last && (out_char_out == CH_NONE))
    else $error("invalid-alphabet result is malformed");

  // A convert transfer makes the block busy.
  a_busy_after_convert: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_CONVERT) |=> !in_ready)
    else $error("input taken during a conversion");

  // No new item while a run is still partly delivered.
  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a run");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind signed_integer_to_base_digits_top sitbd_checker u_sitbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_char_out     (out_char_out),
  .out_last         (out_last),
  .out_base_invalid (out_base_invalid)
);
